@@ src/spk_pkg.sv @@
// Shared types, constants and round functions for the SPECK 64/128 encryptor.
// No dependencies; every other file in src imports this package.
package spk_pkg;

   // Block and key geometry.
   localparam int unsigned WORD_WIDTH          = 32;
   localparam int unsigned KEY_WORDS           = 4;
   localparam int unsigned CSR_ADDR_WIDTH      = 4;
   localparam int unsigned ROUND_COUNT_DEFAULT = 27;

   // Register indexes on the configuration port.
   localparam logic [1:0] KEY_IDX_WORD0 = 2'd0;
   localparam logic [1:0] KEY_IDX_WORD1 = 2'd1;
   localparam logic [1:0] KEY_IDX_WORD2 = 2'd2;
   localparam logic [1:0] KEY_IDX_WORD3 = 2'd3;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // One plaintext request.
   typedef struct packed {
      word_type plain_y;
      word_type plain_x;
   } req_type;

   // One ciphertext result.
   typedef struct packed {
      word_type cipher_y;
      word_type cipher_x;
   } rsp_type;

   // The key as held in the configuration registers.
   typedef struct packed {
      word_type word0;
      word_type word1;
      word_type word2;
      word_type word3;
   } key_type;

   // Everything one round cell hands to the next: the block halves, the
   // current round key and the three schedule lanes, lane0 being the one
   // used in the coming round.
   typedef struct packed {
      word_type x;
      word_type y;
      word_type rk;
      word_type lane0;
      word_type lane1;
      word_type lane2;
   } cell_state_type;

   function automatic word_type ror8(input word_type v);
      return {v[7:0], v[WORD_WIDTH-1:8]};
   endfunction

   function automatic word_type rol3(input word_type v);
      return {v[WORD_WIDTH-4:0], v[WORD_WIDTH-1:WORD_WIDTH-3]};
   endfunction

   // New high word of a round: rotate, add the low word, mix in the key.
   function automatic word_type round_hi(input word_type hi, input word_type lo,
                                         input word_type k);
      return (ror8(hi) + lo) ^ k;
   endfunction

   // New low word of a round, given the new high word.
   function automatic word_type round_lo(input word_type lo, input word_type new_hi);
      return rol3(lo) ^ new_hi;
   endfunction

endpackage

@@ src/spk_key_regs.sv @@
// Key configuration registers behind the APB-style port.
// Depends on spk_pkg for the key struct and register indexes.
module spk_key_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [spk_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [spk_pkg::WORD_WIDTH-1:0]      pwdata,
   output logic [spk_pkg::WORD_WIDTH-1:0]      prdata,
   output logic                                pready,
   output spk_pkg::key_type                    key
);
   import spk_pkg::*;

   key_type    key_ff;
   key_type    key_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   // Write decode for the four key words.
   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            KEY_IDX_WORD0: key_in.word0 = pwdata;
            KEY_IDX_WORD1: key_in.word1 = pwdata;
            KEY_IDX_WORD2: key_in.word2 = pwdata;
            KEY_IDX_WORD3: key_in.word3 = pwdata;
            default:       key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Read back of the addressed word.
   always_comb begin
      unique case (reg_idx)
         KEY_IDX_WORD0: prdata = key_ff.word0;
         KEY_IDX_WORD1: prdata = key_ff.word1;
         KEY_IDX_WORD2: prdata = key_ff.word2;
         KEY_IDX_WORD3: prdata = key_ff.word3;
         default:       prdata = '0;
      endcase
   end

   assign key = key_ff;

endmodule

@@ src/spk_round_cell.sv @@
// One SPECK round cell: a block round and a key schedule round, registered.
// Depends on spk_pkg for the cell state struct and the round functions.
module spk_round_cell #(
   parameter int unsigned ROUND_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  spk_pkg::cell_state_type in_state,
   output logic                    out_valid,
   output spk_pkg::cell_state_type out_state
);
   import spk_pkg::*;

   localparam word_type ROUND_KEY = WORD_WIDTH'(ROUND_INDEX);

   logic           valid_ff;
   cell_state_type state_ff;
   cell_state_type state_in;
   word_type       x_new;
   word_type       lane_new;

   // Block round with the current round key, and schedule round on the
   // active lane keyed by the round index. Lanes rotate so the next lane
   // in turn lands in lane0.
   always_comb begin
      x_new          = round_hi(in_state.x, in_state.y, in_state.rk);
      lane_new       = round_hi(in_state.lane0, in_state.rk, ROUND_KEY);
      state_in.x     = x_new;
      state_in.y     = round_lo(in_state.y, x_new);
      state_in.rk    = round_lo(in_state.rk, lane_new);
      state_in.lane0 = in_state.lane1;
      state_in.lane1 = in_state.lane2;
      state_in.lane2 = lane_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ src/speck64_128_encrypt.sv @@
// Top level of the SPECK 64/128 encryptor: key registers and the round chain.
// Depends on spk_pkg, spk_key_regs and spk_round_cell.
//
// A request is taken in every cycle that start is high; busy is always low,
// so one request per clock is sustained, set by one round cell per round.
// Each request passes through a chain of ROUND_COUNT round cells, one cell
// per clock. Its ciphertext is on rsp_data with rsp_valid high for a single
// cycle, once it has been registered in each round cell in turn, in request
// order. The receiver cannot stall the result, so it must take rsp_data in
// the cycle rsp_valid is high. The key registers are written through the
// APB-style port and must only change while no request is in flight.
module speck64_128_encrypt #(
   parameter int unsigned ROUND_COUNT = spk_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  spk_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output spk_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [spk_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [spk_pkg::WORD_WIDTH-1:0]      pwdata,
   output logic [spk_pkg::WORD_WIDTH-1:0]      prdata,
   output logic                                pready
);
   import spk_pkg::*;

   key_type        key;
   logic           stage_valid [0:ROUND_COUNT];
   cell_state_type stage_state [0:ROUND_COUNT];

   spk_key_regs u_key_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // The chain never stalls.
   assign busy = 1'b0;

   // Head of the chain: the request and a private copy of the key.
   assign stage_valid[0]       = start;
   assign stage_state[0].x     = req_data.plain_x;
   assign stage_state[0].y     = req_data.plain_y;
   assign stage_state[0].rk    = key.word0;
   assign stage_state[0].lane0 = key.word1;
   assign stage_state[0].lane1 = key.word2;
   assign stage_state[0].lane2 = key.word3;

   // One cell per round.
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      spk_round_cell #(
         .ROUND_INDEX (r)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[r]),
         .in_state  (stage_state[r]),
         .out_valid (stage_valid[r+1]),
         .out_state (stage_state[r+1])
      );
   end

   // Tail of the chain drives the result strobe directly.
   assign rsp_valid         = stage_valid[ROUND_COUNT];
   assign rsp_data.cipher_y = stage_state[ROUND_COUNT].y;
   assign rsp_data.cipher_x = stage_state[ROUND_COUNT].x;

endmodule

@@ dv/speck64_128_encrypt_test.sv @@
// Self-checking testbench for the SPECK 64/128 encryptor (speck64_128_encrypt).
// Imports spk_pkg for the request, result and key types; needs only the RTL in src.
// Requests go in through start/busy, the key through the APB port, results are checked in order.
module speck64_128_encrypt_test;
   import spk_pkg::*;

   localparam int unsigned ROUNDS      = ROUND_COUNT_DEFAULT;
   localparam int unsigned PHASES      = 7;
   localparam int unsigned PHASE_ITEMS = 230;
   localparam int unsigned RUN_LIMIT   = 2000000;

   logic                       clock   = 1'b0;
   logic                       reset   = 1'b1;
   logic                       start   = 1'b0;
   logic                       busy;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       psel    = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  paddr   = '0;
   logic [WORD_WIDTH-1:0]      pwdata  = '0;
   logic [WORD_WIDTH-1:0]      prdata;
   logic                       pready;

   // Key as last written, and the ciphertexts still owed by the block.
   key_type     cur_key = '0;
   rsp_type     cipher_expected[$];
   int unsigned error_count = 0;
   bit          idle_on = 1'b0;

   always #5 clock = ~clock;

   speck64_128_encrypt #(
      .ROUND_COUNT(ROUNDS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // One round of the cipher on a (hi, lo) word pair.
   function automatic void speck_mix(inout word_type hi, inout word_type lo,
                                     input word_type k);
      word_type h;
      h  = ({hi[7:0], hi[WORD_WIDTH-1:8]} + lo) ^ k;
      lo = {lo[WORD_WIDTH-4:0], lo[WORD_WIDTH-1:WORD_WIDTH-3]} ^ h;
      hi = h;
   endfunction

   // Full encryption of one block, with the key schedule run alongside.
   function automatic rsp_type expected_cipher(input req_type blk, input key_type key);
      word_type    x;
      word_type    y;
      word_type    rk;
      word_type    sched[3];
      int unsigned sel;
      rsp_type     ct;
      x        = blk.plain_x;
      y        = blk.plain_y;
      rk       = key.word0;
      sched[0] = key.word1;
      sched[1] = key.word2;
      sched[2] = key.word3;
      sel      = 0;
      for (int unsigned r = 0; r < ROUNDS; r++) begin
         speck_mix(x, y, rk);
         speck_mix(sched[sel], rk, word_type'(r));
         sel = (sel == 2) ? 0 : sel + 1;
      end
      ct.cipher_y = y;
      ct.cipher_x = x;
      return ct;
   endfunction

   // Mostly random words, with the extremes mixed in now and then.
   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << $urandom_range(0, WORD_WIDTH - 1);
         3:       return ~(word_type'(1) << $urandom_range(0, WORD_WIDTH - 1));
         default: return word_type'($urandom());
      endcase
   endfunction

   // Send one request, with an optional idle burst ahead of it.
   task automatic send_block(input word_type y, input word_type x);
      req_type blk;
      blk.plain_y = y;
      blk.plain_x = x;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (busy);
      cipher_expected.push_back(expected_cipher(blk, cur_key));
   endtask

   // Wait until every owed ciphertext has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (cipher_expected.size() != 0) @(posedge clock);
   endtask

   // APB write of one key word: setup phase, access until pready, then idle
   // so the next transfer starts on a fresh edge.
   task automatic write_key_word(input logic [1:0] idx, input word_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         KEY_IDX_WORD0: cur_key.word0 = value;
         KEY_IDX_WORD1: cur_key.word1 = value;
         KEY_IDX_WORD2: cur_key.word2 = value;
         KEY_IDX_WORD3: cur_key.word3 = value;
      endcase
      @(posedge clock);
   endtask

   // Load a whole key; the pipeline must be empty first.
   task automatic load_key(input key_type key);
      drain();
      write_key_word(KEY_IDX_WORD0, key.word0);
      write_key_word(KEY_IDX_WORD1, key.word1);
      write_key_word(KEY_IDX_WORD2, key.word2);
      write_key_word(KEY_IDX_WORD3, key.word3);
   endtask

   // Plaintext extremes under the all-zero key left by reset.
   task automatic test_reset_key();
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h8000_0000, 32'h0000_0001);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);
      send_block(32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   // Published test vector; also confirms the predictor on its own.
   task automatic test_known_vector();
      key_type vec_key;
      rsp_type ct;
      req_type blk;
      vec_key.word0 = 32'h0302_0100;
      vec_key.word1 = 32'h0b0a_0908;
      vec_key.word2 = 32'h1312_1110;
      vec_key.word3 = 32'h1b1a_1918;
      blk.plain_y   = 32'h7475_432d;
      blk.plain_x   = 32'h3b72_6574;
      ct = expected_cipher(blk, vec_key);
      if (ct.cipher_y != 32'h454e_028b || ct.cipher_x != 32'h8c6f_a548) begin
         $display("%0t: test vector: expected %h %h, actual %h %h", $time,
                  32'h454e_028b, 32'h8c6f_a548, ct.cipher_y, ct.cipher_x);
         error_count++;
      end
      load_key(vec_key);
      send_block(blk.plain_y, blk.plain_x);
   endtask

   // Key extremes: all ones, then a single bit at the top or bottom end of each word.
   task automatic test_key_extremes();
      key_type k;
      load_key('1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h0000_0001, 32'h8000_0000);
      send_block(32'h1234_5678, 32'h9abc_def0);
      k.word0 = 32'h8000_0000;
      k.word1 = 32'h0000_0001;
      k.word2 = 32'h8000_0000;
      k.word3 = 32'h0000_0001;
      load_key(k);
      send_block('0, '1);
      send_block('1, '0);
   endtask

   // Random traffic over several keys; the last phase runs back to back.
   task automatic test_random_traffic();
      key_type k;
      for (int unsigned p = 0; p < PHASES; p++) begin
         k.word0 = pick_word();
         k.word1 = pick_word();
         k.word2 = pick_word();
         k.word3 = pick_word();
         load_key(k);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            // Idling switches on and off in stretches, never in the last phase.
            if (n % 40 == 0) idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            send_block(pick_word(), pick_word());
         end
      end
      idle_on = 1'b0;
   endtask

   // Compare each result with the oldest owed ciphertext.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (cipher_expected.size() == 0) begin
            $display("%0t: unexpected result, actual %h %h", $time,
                     rsp_data.cipher_y, rsp_data.cipher_x);
            error_count++;
         end else begin
            rsp_type exp_ct;
            exp_ct = cipher_expected.pop_front();
            if (rsp_data.cipher_y !== exp_ct.cipher_y) begin
               $display("%0t: cipher_y expected %h, actual %h", $time,
                        exp_ct.cipher_y, rsp_data.cipher_y);
               error_count++;
            end
            if (rsp_data.cipher_x !== exp_ct.cipher_x) begin
               $display("%0t: cipher_x expected %h, actual %h", $time,
                        exp_ct.cipher_x, rsp_data.cipher_x);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_reset_key();
      test_known_vector();
      test_key_extremes();
      test_random_traffic();
      drain();
      repeat (ROUNDS + 5) @(posedge clock);
      if (error_count == 0 && cipher_expected.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog in case the block stops answering.
   initial begin
      #(RUN_LIMIT * 10);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
src/spk_pkg.sv
src/spk_key_regs.sv
src/spk_round_cell.sv
src/speck64_128_encrypt.sv
dv/speck64_128_encrypt_test.sv
